// ===== sv/onf_pkg.sv =====
`timescale 1ns / 1ps
// shared widths and output limits for the frame orthonormalizer
package onf_pkg;

  // input components, signed q4.16
  localparam int IN_W = 21;
  // output components, signed q1.16
  localparam int OUT_W = 18;
  // first orthogonal column, before normalization
  localparam int U1_W = IN_W + 2;
  // second orthogonal column, before normalization
  localparam int U2_W = IN_W + 3;

  localparam int FRAC_BITS_DEF = 16;

  // saturation limits of an output component
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN_MAG = 131072;

endpackage

// ===== sv/onf_delay.sv =====
`timescale 1ns / 1ps
// fixed-length shift register for side data that rides along a pipeline
module onf_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr [D];

  // shift one stage per cycle
  always_ff @(posedge clk) begin
    sr[0] <= din;
    for (int k = 1; k < D; k++) begin
      sr[k] <= sr[k-1];
    end
  end

  assign dout = sr[D-1];

endmodule

// ===== sv/onf_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
// the caller guarantees num < den * 2^QW
module onf_div #(
  parameter int NW = 66,
  parameter int DW = 43,
  parameter int QW = 22
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          vld_in,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          vld_out,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_s [1:QW];
  logic [QW-1:0] sh_s  [1:QW];
  logic [DW-1:0] den_s [1:QW];
  logic          vld_s [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] r_in;
    logic [QW-1:0] s_in;
    logic [DW-1:0] d_in;
    logic          v_in;
    logic [DW:0]   t;
    logic          ge;

    // stage zero takes the top of the dividend as its remainder
    if (k == 0) begin : g_first
      assign r_in = DW'(num >> QW);
      assign s_in = num[QW-1:0];
      assign d_in = den;
      assign v_in = vld_in;
    end else begin : g_next
      assign r_in = rem_s[k];
      assign s_in = sh_s[k];
      assign d_in = den_s[k];
      assign v_in = vld_s[k];
    end

    // shift in the next dividend bit and try the subtraction
    assign t  = {r_in, s_in[QW-1]};
    assign ge = (t >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_s[k+1] <= ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
      sh_s[k+1]  <= {s_in[QW-2:0], ge};
      den_s[k+1] <= d_in;
    end
  end

  assign quo     = sh_s[QW];
  assign vld_out = vld_s[QW];

endmodule

// ===== sv/onf_sqrt.sv =====
`timescale 1ns / 1ps
// pipelined integer square root (floor), one root bit per stage
module onf_sqrt #(
  parameter int RW = 18
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            vld_in,
  input  logic [2*RW-1:0] rad,
  output logic            vld_out,
  output logic [RW-1:0]   root
);

  logic [RW:0]     rm_s [1:RW];
  logic [RW-1:0]   rt_s [1:RW];
  logic [2*RW-1:0] xs_s [1:RW];
  logic            vld_s [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW:0]     m_in;
    logic [RW-1:0]   r_in;
    logic [2*RW-1:0] x_in;
    logic            v_in;
    logic [RW+2:0]   t;
    logic [RW+2:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign m_in = '0;
      assign r_in = '0;
      assign x_in = rad;
      assign v_in = vld_in;
    end else begin : g_next
      assign m_in = rm_s[k];
      assign r_in = rt_s[k];
      assign x_in = xs_s[k];
      assign v_in = vld_s[k];
    end

    // bring down two radicand bits, test against 4*root+1
    assign t     = {m_in, x_in[2*RW-1 -: 2]};
    assign trial = {1'b0, r_in, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rm_s[k+1] <= ge ? (RW+1)'(t - trial) : t[RW:0];
      rt_s[k+1] <= {r_in[RW-2:0], ge};
      xs_s[k+1] <= x_in << 2;
    end
  end

  assign root    = rt_s[RW];
  assign vld_out = vld_s[RW];

endmodule

// ===== sv/onf_proj.sv =====
`timescale 1ns / 1ps
// removes the rounded projection of v on u from base: res = base - P(u, v)
module onf_proj #(
  parameter int UW = 21,
  parameter int VW = 21,
  parameter int BW = 21,
  parameter int RW = 23,
  parameter int XW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vld_in,
  input  logic signed [UW-1:0] u [3],
  input  logic signed [VW-1:0] v [3],
  input  logic signed [BW-1:0] base [3],
  input  logic [XW-1:0]        side,
  output logic                 vld_out,
  output logic signed [RW-1:0] res [3],
  output logic signed [UW-1:0] u_out [3],
  output logic [XW-1:0]        side_out
);

  localparam int PW   = UW + VW;
  localparam int DVW  = PW + 2;
  localparam int MAGW = PW + 1;
  localparam int H    = (MAGW + 1) / 2;
  localparam int HW   = MAGW - H;
  localparam int SQW  = 2 * UW;
  localparam int QW   = VW + 1;
  localparam int NW   = MAGW + UW + 2;
  localparam int DNW  = SQW + 1;
  localparam int DLW  = 3 * UW + 3 * BW + XW;

  logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_q;
  logic [SQW-1:0]       puu_s1 [3];
  logic signed [PW-1:0] puv_s1 [3];
  logic signed [UW-1:0] u_s1 [3];
  logic [SQW-1:0]       duu_s2;
  logic signed [DVW-1:0] duv_s2;
  logic signed [UW-1:0] u_s2 [3];
  logic [MAGW-1:0]      mag_s3;
  logic                 ndv_s3;
  logic [UW-1:0]        ua_s3 [3];
  logic                 nu_s3 [3];
  logic [SQW-1:0]       duu_s3;
  logic [H+UW-1:0]      pl_s4 [3];
  logic [HW+UW-1:0]     ph_s4 [3];
  logic [SQW-1:0]       duu_s4;
  logic [2:0]           flip_s4;
  logic                 zero_s4;
  logic [NW-1:0]        num_s5 [3];
  logic [DNW-1:0]       den_s5;
  logic [2:0]           flip_s5;
  logic                 zero_s5;
  logic [QW-1:0]        quo [3];
  logic [3:0]           fz_d;
  logic [DLW-1:0]       dl_in, dl_out;
  logic signed [UW-1:0] u_d [3];
  logic signed [BW-1:0] b_d [3];
  logic signed [QW:0]   p_c [3];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s1  <= 1'b0;
      vld_s2  <= 1'b0;
      vld_s3  <= 1'b0;
      vld_s4  <= 1'b0;
      vld_s5  <= 1'b0;
      vld_out <= 1'b0;
    end else begin
      vld_s1  <= vld_in;
      vld_s2  <= vld_s1;
      vld_s3  <= vld_s2;
      vld_s4  <= vld_s3;
      vld_s5  <= vld_s4;
      vld_out <= vld_q;
    end
  end

  // front end: dot products, magnitudes, wide product in two halves
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      puu_s1[i] <= u[i] * u[i];
      puv_s1[i] <= u[i] * v[i];
      u_s1[i]   <= u[i];
    end
    duu_s2 <= SQW'((SQW+2)'(puu_s1[0]) + (SQW+2)'(puu_s1[1]) + (SQW+2)'(puu_s1[2]));
    duv_s2 <= DVW'(puv_s1[0]) + DVW'(puv_s1[1]) + DVW'(puv_s1[2]);
    u_s2   <= u_s1;
    mag_s3 <= duv_s2[DVW-1] ? MAGW'(-duv_s2) : MAGW'(duv_s2);
    ndv_s3 <= duv_s2[DVW-1];
    duu_s3 <= duu_s2;
    for (int i = 0; i < 3; i++) begin
      ua_s3[i] <= u_s2[i][UW-1] ? UW'(-u_s2[i]) : UW'(u_s2[i]);
      nu_s3[i] <= u_s2[i][UW-1];
    end
    for (int i = 0; i < 3; i++) begin
      pl_s4[i]   <= mag_s3[H-1:0] * ua_s3[i];
      ph_s4[i]   <= mag_s3[MAGW-1:H] * ua_s3[i];
      flip_s4[i] <= ndv_s3 ^ nu_s3[i];
    end
    duu_s4  <= duu_s3;
    zero_s4 <= (duu_s3 == '0);
    // numerator 2*|uv|*|ui| + uu over 2*uu rounds half away from zero
    for (int i = 0; i < 3; i++) begin
      num_s5[i] <= (NW'(ph_s4[i]) << (H + 1)) + (NW'(pl_s4[i]) << 1) + NW'(duu_s4);
    end
    den_s5  <= {duu_s4, 1'b0};
    flip_s5 <= flip_s4;
    zero_s5 <= zero_s4;
  end

  // one divider per component
  for (genvar i = 0; i < 3; i++) begin : g_div
    if (i == 0) begin : g_lead
      onf_div #(.NW(NW), .DW(DNW), .QW(QW)) u_div (
        .clk(clk), .rst(rst), .vld_in(vld_s5), .num(num_s5[i]), .den(den_s5),
        .vld_out(vld_q), .quo(quo[i])
      );
    end else begin : g_rest
      onf_div #(.NW(NW), .DW(DNW), .QW(QW)) u_div (
        .clk(clk), .rst(rst), .vld_in(vld_s5), .num(num_s5[i]), .den(den_s5),
        .vld_out(), .quo(quo[i])
      );
    end
  end

  // signs and zero flag wait for the dividers
  onf_delay #(.W(4), .D(QW)) u_fz (
    .clk(clk), .din({flip_s5, zero_s5}), .dout(fz_d)
  );

  // u, base and side data wait for the whole front end
  assign dl_in = {u[0], u[1], u[2], base[0], base[1], base[2], side};

  onf_delay #(.W(DLW), .D(QW + 5)) u_dl (
    .clk(clk), .din(dl_in), .dout(dl_out)
  );

  assign u_d[0] = dl_out[DLW-1 -: UW];
  assign u_d[1] = dl_out[DLW-1-UW -: UW];
  assign u_d[2] = dl_out[DLW-1-2*UW -: UW];
  assign b_d[0] = dl_out[XW+3*BW-1 -: BW];
  assign b_d[1] = dl_out[XW+2*BW-1 -: BW];
  assign b_d[2] = dl_out[XW+BW-1 -: BW];

  // signed projection, zero when u has no length
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fz_d[0]) begin
        p_c[i] = '0;
      end else if (fz_d[i+1]) begin
        p_c[i] = -$signed({1'b0, quo[i]});
      end else begin
        p_c[i] = $signed({1'b0, quo[i]});
      end
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      res[i]   <= RW'(b_d[i]) - RW'(p_c[i]);
      u_out[i] <= u_d[i];
    end
    side_out <= dl_out[XW-1:0];
  end

endmodule

// ===== sv/onf_unit.sv =====
`timescale 1ns / 1ps
// scales one column to unit length: sign(u_i) * round(|u_i| * 2^F / |u|)
module onf_unit #(
  parameter int UW = 21,
  parameter int F  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              vld_in,
  input  logic signed [UW-1:0]              u [3],
  output logic                              vld_out,
  output logic signed [onf_pkg::OUT_W-1:0]  o [3],
  output logic                              zero
);

  localparam int SQW = 2 * UW;
  localparam int QW  = 2 * F + 3;
  localparam int NW  = SQW + 2 * F + 2;
  localparam int RS  = F + 2;
  localparam int MW  = F + 3;
  localparam int SW  = (MW > 19) ? MW : 19;
  localparam int OW  = onf_pkg::OUT_W;

  logic           vld_s1, vld_s2, vld_q, vld_r;
  logic [SQW-1:0] sq_s1 [3];
  logic [2:0]     neg_s1;
  logic [SQW-1:0] sq_s2 [3];
  logic [2:0]     neg_s2;
  logic [SQW-1:0] d_s2;
  logic [QW-1:0]  quo [3];
  logic [RS-1:0]  root [3];
  logic [3:0]     nz_d;
  logic [SW-1:0]  mx_c [3];
  logic [OW-1:0]  val_c [3];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s1  <= 1'b0;
      vld_s2  <= 1'b0;
      vld_out <= 1'b0;
    end else begin
      vld_s1  <= vld_in;
      vld_s2  <= vld_s1;
      vld_out <= vld_r;
    end
  end

  // squares and squared length
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_s1[i]  <= u[i] * u[i];
      neg_s1[i] <= u[i][UW-1];
    end
    sq_s2  <= sq_s1;
    neg_s2 <= neg_s1;
    d_s2   <= SQW'((SQW+2)'(sq_s1[0]) + (SQW+2)'(sq_s1[1]) + (SQW+2)'(sq_s1[2]));
  end

  // 4 * u_i^2 * 2^2F / |u|^2, then its floor root
  for (genvar i = 0; i < 3; i++) begin : g_lane
    if (i == 0) begin : g_lead
      logic vld_m;
      onf_div #(.NW(NW), .DW(SQW), .QW(QW)) u_div (
        .clk(clk), .rst(rst), .vld_in(vld_s2),
        .num({sq_s2[i], {(2*F+2){1'b0}}}), .den(d_s2),
        .vld_out(vld_m), .quo(quo[i])
      );
      onf_sqrt #(.RW(RS)) u_sqrt (
        .clk(clk), .rst(rst), .vld_in(vld_m), .rad((2*RS)'(quo[i])),
        .vld_out(vld_q), .root(root[i])
      );
    end else begin : g_rest
      onf_div #(.NW(NW), .DW(SQW), .QW(QW)) u_div (
        .clk(clk), .rst(rst), .vld_in(vld_s2),
        .num({sq_s2[i], {(2*F+2){1'b0}}}), .den(d_s2),
        .vld_out(), .quo(quo[i])
      );
      onf_sqrt #(.RW(RS)) u_sqrt (
        .clk(clk), .rst(rst), .vld_in(vld_s2), .rad((2*RS)'(quo[i])),
        .vld_out(), .root(root[i])
      );
    end
  end

  assign vld_r = vld_q;

  // signs and zero-length flag wait for divider and root
  onf_delay #(.W(4), .D(QW + RS)) u_nz (
    .clk(clk), .din({neg_s2, (d_s2 == '0)}), .dout(nz_d)
  );

  // round the half-unit root, saturate, apply the sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mx_c[i] = SW'((MW'(root[i]) + MW'(1)) >> 1);
      if (nz_d[0]) begin
        val_c[i] = '0;
      end else if (nz_d[i+1]) begin
        if (mx_c[i] > SW'(onf_pkg::OUT_MIN_MAG)) begin
          mx_c[i] = SW'(onf_pkg::OUT_MIN_MAG);
        end
        val_c[i] = OW'(SW'(0) - mx_c[i]);
      end else begin
        if (mx_c[i] > SW'(onf_pkg::OUT_MAX)) begin
          mx_c[i] = SW'(onf_pkg::OUT_MAX);
        end
        val_c[i] = OW'(mx_c[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      o[i] <= $signed(val_c[i]);
    end
    zero <= nz_d[0];
  end

endmodule

// ===== sv/orthonormalize_3x3_frame.sv =====
`timescale 1ns / 1ps
// Gram-Schmidt orthonormalization of a 3x3 frame, top level
// throughput: one request per cycle; busy is low except the cycle after reset
// the latency is set by the bit-per-stage divider chains (two projections and
// the normalization) and the bit-per-stage square root chain
// reset: synchronous, clears all valid bits; results cannot be stalled
module orthonormalize_3x3_frame #(
  parameter int FRAC_BITS = onf_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  input  logic signed [onf_pkg::IN_W-1:0]  in_c0_x,
  input  logic signed [onf_pkg::IN_W-1:0]  in_c0_y,
  input  logic signed [onf_pkg::IN_W-1:0]  in_c0_z,
  input  logic signed [onf_pkg::IN_W-1:0]  in_c1_x,
  input  logic signed [onf_pkg::IN_W-1:0]  in_c1_y,
  input  logic signed [onf_pkg::IN_W-1:0]  in_c1_z,
  input  logic signed [onf_pkg::IN_W-1:0]  in_c2_x,
  input  logic signed [onf_pkg::IN_W-1:0]  in_c2_y,
  input  logic signed [onf_pkg::IN_W-1:0]  in_c2_z,
  output logic signed [onf_pkg::OUT_W-1:0] out_c0_x,
  output logic signed [onf_pkg::OUT_W-1:0] out_c0_y,
  output logic signed [onf_pkg::OUT_W-1:0] out_c0_z,
  output logic signed [onf_pkg::OUT_W-1:0] out_c1_x,
  output logic signed [onf_pkg::OUT_W-1:0] out_c1_y,
  output logic signed [onf_pkg::OUT_W-1:0] out_c1_z,
  output logic signed [onf_pkg::OUT_W-1:0] out_c2_x,
  output logic signed [onf_pkg::OUT_W-1:0] out_c2_y,
  output logic signed [onf_pkg::OUT_W-1:0] out_c2_z,
  output logic degenerate
);

  localparam int IW    = onf_pkg::IN_W;
  localparam int W1    = onf_pkg::U1_W;
  localparam int W2    = onf_pkg::U2_W;
  localparam int OW    = onf_pkg::OUT_W;
  localparam int LAT_P = IW + 7;
  localparam int LAT_U = 3 * FRAC_BITS + 8;
  localparam int LAT   = 2 * LAT_P + LAT_U + 2;

  logic                 in_vld;
  logic signed [IW-1:0] v0_r [3];
  logic signed [IW-1:0] v1_r [3];
  logic signed [IW-1:0] v2_r [3];
  logic                 a_vld, b_vld;
  logic signed [W1-1:0] u1_a [3];
  logic signed [IW-1:0] v0_a [3];
  logic [3*IW-1:0]      v2_pk;
  logic signed [IW-1:0] v2_a [3];
  logic signed [W1-1:0] w2_a [3];
  logic signed [W2-1:0] u2_b [3];
  logic signed [W1-1:0] u1_b [3];
  logic [3*IW-1:0]      v0_pk;
  logic signed [IW-1:0] v0_b [3];
  logic                 c_vld;
  logic signed [OW-1:0] o0 [3];
  logic signed [OW-1:0] o1 [3];
  logic signed [OW-1:0] o2 [3];
  logic [2:0]           zr;

  // request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      busy   <= 1'b1;
    end else begin
      in_vld <= start && !busy;
      busy   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    v0_r[0] <= in_c0_x;
    v0_r[1] <= in_c0_y;
    v0_r[2] <= in_c0_z;
    v1_r[0] <= in_c1_x;
    v1_r[1] <= in_c1_y;
    v1_r[2] <= in_c1_z;
    v2_r[0] <= in_c2_x;
    v2_r[1] <= in_c2_y;
    v2_r[2] <= in_c2_z;
  end

  // column 1 loses its projection on column 0; column 2 rides along
  onf_proj #(.UW(IW), .VW(IW), .BW(IW), .RW(W1), .XW(3*IW)) u_proj01 (
    .clk(clk), .rst(rst), .vld_in(in_vld), .u(v0_r), .v(v1_r), .base(v1_r),
    .side({v2_r[0], v2_r[1], v2_r[2]}),
    .vld_out(a_vld), .res(u1_a), .u_out(v0_a), .side_out(v2_pk)
  );

  // column 2 loses its projection on column 0
  onf_proj #(.UW(IW), .VW(IW), .BW(IW), .RW(W1), .XW(1)) u_proj02 (
    .clk(clk), .rst(rst), .vld_in(in_vld), .u(v0_r), .v(v2_r), .base(v2_r),
    .side(1'b0),
    .vld_out(), .res(w2_a), .u_out(), .side_out()
  );

  assign v2_a[0] = v2_pk[3*IW-1 -: IW];
  assign v2_a[1] = v2_pk[2*IW-1 -: IW];
  assign v2_a[2] = v2_pk[IW-1:0];

  // then its projection on the unnormalized column 1
  onf_proj #(.UW(W1), .VW(IW), .BW(W1), .RW(W2), .XW(3*IW)) u_proj12 (
    .clk(clk), .rst(rst), .vld_in(a_vld), .u(u1_a), .v(v2_a), .base(w2_a),
    .side({v0_a[0], v0_a[1], v0_a[2]}),
    .vld_out(b_vld), .res(u2_b), .u_out(u1_b), .side_out(v0_pk)
  );

  assign v0_b[0] = v0_pk[3*IW-1 -: IW];
  assign v0_b[1] = v0_pk[2*IW-1 -: IW];
  assign v0_b[2] = v0_pk[IW-1:0];

  // normalize all three columns side by side
  onf_unit #(.UW(IW), .F(FRAC_BITS)) u_unit0 (
    .clk(clk), .rst(rst), .vld_in(b_vld), .u(v0_b),
    .vld_out(c_vld), .o(o0), .zero(zr[0])
  );

  onf_unit #(.UW(W1), .F(FRAC_BITS)) u_unit1 (
    .clk(clk), .rst(rst), .vld_in(b_vld), .u(u1_b),
    .vld_out(), .o(o1), .zero(zr[1])
  );

  onf_unit #(.UW(W2), .F(FRAC_BITS)) u_unit2 (
    .clk(clk), .rst(rst), .vld_in(b_vld), .u(u2_b),
    .vld_out(), .o(o2), .zero(zr[2])
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_c0_x   <= o0[0];
    out_c0_y   <= o0[1];
    out_c0_z   <= o0[2];
    out_c1_x   <= o1[0];
    out_c1_y   <= o1[1];
    out_c1_z   <= o1[2];
    out_c2_x   <= o2[0];
    out_c2_y   <= o2[1];
    out_c2_z   <= o2[2];
    degenerate <= |zr;
  end

  // every accepted request is answered with done
  a_req_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request did not complete on time");

  a_done_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a request");

  // a zero first column must be flagged
  a_zero_col: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && in_c0_x == '0 && in_c0_y == '0 && in_c0_z == '0)
      |-> ##LAT (done && degenerate))
    else $error("zero column not flagged");

  // a column of nonzero length never normalizes to all zeros
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !degenerate) |->
      ((out_c0_x != '0 || out_c0_y != '0 || out_c0_z != '0) &&
       (out_c1_x != '0 || out_c1_y != '0 || out_c1_z != '0) &&
       (out_c2_x != '0 || out_c2_y != '0 || out_c2_z != '0)))
    else $error("unit column came out zero");

endmodule
